[src/kwm_pkg.sv]
// Shared constants and control/status types for the k-way merge engine.
`default_nettype none
package kwm_pkg;

    localparam int DATA_W    = 32;
    localparam int SRC_W     = 3;
    localparam int CFG_W     = 4;
    localparam int DIG_W     = 4;
    localparam int NUM_DIG   = DATA_W / DIG_W;
    localparam int DCNT_W    = $clog2(NUM_DIG);
    localparam int NUM_RESET = 8;

    // Control from the merge sequencer to the head store / min search.
    typedef struct packed {
        logic start;
        logic wr_en;
    } t_search_ctl;

    // Status back from the min search.
    typedef struct packed {
        logic busy;
        logic found;
    } t_search_stat;

endpackage
`default_nettype wire

[src/kwm_min_search.sv]
// Head registers and digit-serial minimum search over the live heads.
`default_nettype none
module kwm_min_search import kwm_pkg::*; #(
    parameter int MAX_SOURCES = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire t_search_ctl                    i_ctl,
    input  wire logic [$clog2(MAX_SOURCES)-1:0] i_wr_idx,
    input  wire logic [DATA_W-1:0]              i_wr_value,
    input  wire logic [MAX_SOURCES-1:0]         i_live,
    output t_search_stat                        o_stat,
    output logic [$clog2(MAX_SOURCES)-1:0]      o_best_idx,
    output logic [DATA_W-1:0]                   o_best_value
);

    localparam int IDX_W = $clog2(MAX_SOURCES);

    logic [DATA_W-1:0]      r_head [MAX_SOURCES];
    logic [MAX_SOURCES-1:0] r_cand;
    logic [MAX_SOURCES-1:0] n_cand;
    logic [DCNT_W-1:0]      r_dcnt;
    logic                   r_busy;
    logic [IDX_W-1:0]       w_best;

    // Heads rotate one digit per search cycle; after a full search of all digits they are back home.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && !r_busy) begin
            r_head[i_wr_idx] <= i_wr_value;
        end else if (r_busy) begin
            for (int i = 0; i < MAX_SOURCES; i++) begin
                r_head[i] <= {r_head[i][DATA_W-DIG_W-1:0], r_head[i][DATA_W-1:DATA_W-DIG_W]};
            end
        end
    end

    // MSB-first elimination: drop candidates with a 1 where some candidate has a 0.
    always_comb begin
        logic [MAX_SOURCES-1:0] c;
        logic [MAX_SOURCES-1:0] z;
        logic                   bt;
        c = r_cand;
        z = '0;
        for (int b = DIG_W - 1; b >= 0; b--) begin
            for (int i = 0; i < MAX_SOURCES; i++) begin
                bt = r_head[i][DATA_W-DIG_W+b];
                // sign bit of the top digit: invert for two's complement order
                if (r_dcnt == '0 && b == DIG_W - 1) begin
                    bt = ~bt;
                end
                z[i] = c[i] & ~bt;
            end
            if (|z) begin
                c = z;
            end
        end
        n_cand = c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cand <= '0;
            r_dcnt <= '0;
        end else if (r_busy) begin
            r_cand <= n_cand;
            r_dcnt <= r_dcnt + 1'b1;
            if (r_dcnt == DCNT_W'(NUM_DIG - 1)) begin
                r_busy <= 1'b0;
            end
        end else if (i_ctl.start) begin
            r_cand <= i_live;
            r_dcnt <= '0;
            r_busy <= 1'b1;
        end
    end

    // Ties: lowest index among survivors.
    always_comb begin
        w_best = '0;
        for (int i = MAX_SOURCES - 1; i >= 0; i--) begin
            if (r_cand[i]) begin
                w_best = IDX_W'(i);
            end
        end
    end

    assign o_best_idx   = w_best;
    assign o_best_value = r_head[w_best];
    assign o_stat.busy  = r_busy;
    assign o_stat.found = |r_cand;

    a_start_dcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> r_dcnt == '0)
        else $error("search started with nonzero digit count");

    a_cand_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> (r_cand & ~$past(r_cand)) == '0)
        else $error("candidate set grew during search");

    a_cand_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cand != '0) |=> r_cand != '0)
        else $error("elimination emptied candidate set");

endmodule
`default_nettype wire

[src/k_way_merge_engine_core.sv]
// Top level of the k-way merge engine: fill/drain sequencer and result register.
`default_nettype none
// K-way merge engine. Up to num_sources (clamped to 1..MAX_SOURCES) ascending
// streams are merged into one ascending stream. After reset or any write of
// num_sources the block is in fill: each source sends one request carrying its
// head value or an exhausted mark; nothing comes out until all have answered.
// Then each result carries the smallest live head and its source, and the next
// request must refill that source (new value or exhausted). A request from a
// source beyond the count, a second answer in fill, or a wrong source while
// draining is dropped with an error result; the awaited source is unchanged.
// Equal heads go to the lower source index. When no head is live, a done
// result is given and the block returns to fill. A selection runs through
// accept, the search and the result load, which waits while the output
// register holds an untaken result. The min search looks at one 4-bit digit
// of all heads per cycle, MSB first, over DATA_W/4 digits. Input is not
// taken while a result waits in the output register unless it is being
// taken in the same cycle. num_sources must be written only while the block
// is idle; the block itself does not enforce this. A write restarts the merge.
module k_way_merge_engine_core import kwm_pkg::*; #(
    parameter int MAX_SOURCES = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [CFG_W-1:0]         i_cfg_wr_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [SRC_W-1:0]         i_source,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire logic                     i_exhausted,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed [DATA_W-1:0]      o_out_value,
    output logic [SRC_W-1:0]              o_out_source,
    output logic                          o_done_res,
    output logic                          o_error
);

    localparam int IDX_W = $clog2(MAX_SOURCES);
    localparam int CNT_W = $clog2(MAX_SOURCES + 1);
    localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state_e;

    t_state_e               r_state, n_state;
    logic [CFG_W-1:0]       r_num, n_num;
    logic [MAX_SOURCES-1:0] r_live, n_live;
    logic [MAX_SOURCES-1:0] r_ans, n_ans;
    logic                   r_filling, n_filling;
    logic [SRC_W-1:0]       r_await, n_await;
    logic                   r_out_valid, n_out_valid;
    logic [DATA_W-1:0]      r_out_value, n_out_value;
    logic [SRC_W-1:0]       r_out_source, n_out_source;
    logic                   r_done, n_done;
    logic                   r_err, n_err;

    logic [CW-1:0]          w_n;
    logic [MAX_SOURCES-1:0] w_act;
    logic [IDX_W-1:0]       w_idx;
    logic                   w_in_range;
    logic                   w_slot_free;
    logic                   w_accept;
    t_search_ctl            w_ctl;
    t_search_stat           w_stat;
    logic [IDX_W-1:0]       w_best_idx;
    logic [DATA_W-1:0]      w_best_value;

    // Effective source count: 0 acts as 1, above MAX_SOURCES clamps.
    always_comb begin
        if (r_num == '0) begin
            w_n = CW'(1);
        end else if (CW'(r_num) > CW'(MAX_SOURCES)) begin
            w_n = CW'(MAX_SOURCES);
        end else begin
            w_n = CW'(r_num);
        end
        for (int i = 0; i < MAX_SOURCES; i++) begin
            w_act[i] = CW'(i) < w_n;
        end
    end

    assign w_in_range  = CW'(i_source) < w_n;
    assign w_idx       = IDX_W'(i_source);
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && w_slot_free;
    assign w_accept    = i_in_valid && o_in_ready;

    kwm_min_search #(
        .MAX_SOURCES(MAX_SOURCES)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_wr_idx    (w_idx),
        .i_wr_value  (i_value),
        .i_live      (n_live & w_act),
        .o_stat      (w_stat),
        .o_best_idx  (w_best_idx),
        .o_best_value(w_best_value)
    );

    always_comb begin
        n_state      = r_state;
        n_num        = r_num;
        n_live       = r_live;
        n_ans        = r_ans;
        n_filling    = r_filling;
        n_await      = r_await;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_source = r_out_source;
        n_done       = r_done;
        n_err        = r_err;
        w_ctl        = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (!w_in_range
                        || (r_filling && r_ans[w_idx])
                        || (!r_filling && i_source != r_await)) begin
                        // dropped request
                        n_out_valid  = 1'b1;
                        n_out_value  = '0;
                        n_out_source = '0;
                        n_done       = 1'b0;
                        n_err        = 1'b1;
                    end else begin
                        if (i_exhausted) begin
                            n_live[w_idx] = 1'b0;
                        end else begin
                            n_live[w_idx] = 1'b1;
                            w_ctl.wr_en   = 1'b1;
                        end
                        if (r_filling) begin
                            n_ans[w_idx] = 1'b1;
                        end
                        if (!r_filling || ((n_ans & w_act) == w_act)) begin
                            w_ctl.start = 1'b1;
                            n_state     = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH: begin
                if (!w_stat.busy && w_slot_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_err       = 1'b0;
                    if (w_stat.found) begin
                        n_out_value  = w_best_value;
                        n_out_source = SRC_W'(w_best_idx);
                        n_done       = 1'b0;
                        n_filling    = 1'b0;
                        n_await      = SRC_W'(w_best_idx);
                    end else begin
                        // all exhausted: done, back to fill
                        n_out_value  = '0;
                        n_out_source = '0;
                        n_done       = 1'b1;
                        n_live       = '0;
                        n_ans        = '0;
                        n_filling    = 1'b1;
                        n_await      = '0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // config write restarts the merge
        if (i_cfg_wr_en) begin
            n_num     = i_cfg_wr_data;
            n_live    = '0;
            n_ans     = '0;
            n_filling = 1'b1;
            n_await   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_num       <= CFG_W'(NUM_RESET);
            r_live      <= '0;
            r_ans       <= '0;
            r_filling   <= 1'b1;
            r_await     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_num       <= n_num;
            r_live      <= n_live;
            r_ans       <= n_ans;
            r_filling   <= n_filling;
            r_await     <= n_await;
            r_out_valid <= n_out_valid;
        end
        r_out_value  <= n_out_value;
        r_out_source <= n_out_source;
        r_done       <= n_done;
        r_err        <= n_err;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_source = r_out_source;
    assign o_done_res   = r_done;
    assign o_error      = r_err;

    a_no_accept_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> !o_in_ready)
        else $error("request accepted during search");

    a_search_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_stat.busy) |-> r_state == ST_SEARCH)
        else $error("search running outside search state");

    a_done_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> (r_filling && r_live == '0))
        else $error("done result without restart to fill");

endmodule
`default_nettype wire

[sim/kwm_merge_monitor.sv]
`timescale 1ns / 1ps
// Request/result monitor for the k-way merge engine: tracks merge state and checks results.
module kwm_merge_monitor import kwm_pkg::*; #(
    parameter int MAX_SOURCES = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_W-1:0]         i_cfg_wr_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [SRC_W-1:0]         i_source,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_exhausted,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic signed [DATA_W-1:0] i_out_value,
    input  logic [SRC_W-1:0]         i_out_source,
    input  logic                     i_done_res,
    input  logic                     i_error,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam int SHOWN_MISMATCHES = 10;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [SRC_W-1:0]         src;
        logic                     done;
        logic                     err;
    } t_merge_out;

    logic signed [DATA_W-1:0] head_val [MAX_SOURCES];
    logic [MAX_SOURCES-1:0]   head_live;
    logic [MAX_SOURCES-1:0]   answered;
    logic                     filling;
    logic [SRC_W-1:0]         awaited;
    logic [CFG_W-1:0]         src_cfg;
    t_merge_out               merge_out_q [$];
    int                       fail_total = 0;

    // Register value clamped to 1..MAX_SOURCES.
    function automatic int active_sources();
        if (src_cfg == '0) return 1;
        if (int'(src_cfg) > MAX_SOURCES) return MAX_SOURCES;
        return int'(src_cfg);
    endfunction

    task automatic restart_merge();
        head_live = '0;
        answered  = '0;
        filling   = 1'b1;
        awaited   = '0;
    endtask

    // Append one predicted result.
    task automatic expect_result(input t_merge_out r);
        merge_out_q = {merge_out_q, r};
    endtask

    // Smallest live head wins, lowest index on ties; no live head means done.
    task automatic emit_min();
        int n;
        int i;
        int best;
        bit found;
        n = active_sources();
        best = 0;
        found = 1'b0;
        for (i = 0; i < n; i++) begin
            if (head_live[i] && (!found || head_val[i] < head_val[best])) begin
                best = i;
                found = 1'b1;
            end
        end
        if (found) begin
            filling = 1'b0;
            awaited = SRC_W'(best);
            expect_result(t_merge_out'{value: head_val[best], src: SRC_W'(best),
                                       done: 1'b0, err: 1'b0});
        end else begin
            restart_merge();
            expect_result(t_merge_out'{value: '0, src: '0, done: 1'b1, err: 1'b0});
        end
    endtask

    task automatic take_request(input logic [SRC_W-1:0] s,
                                input logic signed [DATA_W-1:0] v,
                                input logic ex);
        int n;
        logic [MAX_SOURCES-1:0] all_in;
        n = active_sources();
        all_in = {MAX_SOURCES{1'b1}} >> (MAX_SOURCES - n);
        // Beyond the count, second answer in fill, or wrong source while draining.
        if (int'(s) >= n || (filling && answered[s]) || (!filling && s != awaited)) begin
            expect_result(t_merge_out'{value: '0, src: '0, done: 1'b0, err: 1'b1});
            return;
        end
        if (ex) begin
            head_live[s] = 1'b0;
        end else begin
            head_val[s]  = v;
            head_live[s] = 1'b1;
        end
        if (filling) begin
            answered[s] = 1'b1;
            if ((answered & all_in) != all_in) return;
        end
        emit_min();
    endtask

    task automatic note_failure(input string what, input t_merge_out want,
                                input t_merge_out got);
        fail_total++;
        if (fail_total <= SHOWN_MISMATCHES) begin
            $write("%0t: %s: expected value=%0d source=%0d done=%0b error=%0b, ",
                   $time, what, want.value, want.src, want.done, want.err);
            $display("got value=%0d source=%0d done=%0b error=%0b",
                     got.value, got.src, got.done, got.err);
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_merge_out got;
        t_merge_out want;
        if (!i_rst_n) begin
            src_cfg = CFG_W'(MAX_SOURCES);
            restart_merge();
            merge_out_q.delete();
        end else begin
            // Results first: a request taken at this edge cannot answer at it.
            if (i_out_valid && i_out_ready) begin
                got = '{value: i_out_value, src: i_out_source, done: i_done_res, err: i_error};
                if (merge_out_q.size() == 0) begin
                    note_failure("result with nothing expected", '0, got);
                end else begin
                    want = merge_out_q.pop_front();
                    if (got !== want) note_failure("result mismatch", want, got);
                end
            end
            if (i_cfg_wr_en) begin
                src_cfg = i_cfg_wr_data;
                restart_merge();
            end
            if (i_in_valid && i_in_ready) take_request(i_source, i_value, i_exhausted);
        end
        o_pending    <= merge_out_q.size();
        o_fail_count <= fail_total;
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Testbench top for the k-way merge engine: request stimulus, receiver stalls and verdict.
module testbench;
    import kwm_pkg::*;

    localparam int MAX_SOURCES     = 8;
    localparam int MAX_RUN_LEN     = 4;      // longest sorted stream per source
    localparam int NOISE_PCT       = 8;      // chance of a stray request before a real one
    localparam int ITEMS_PER_PHASE = 165;    // four phases, about 660 random requests
    localparam int HOLD_CYCLES     = 240;    // long receiver hold-off, forces input stall
    localparam int SETTLE_CYCLES   = 16;     // lets a selection finish, plus margin
    localparam int LIMIT_CYCLES    = 500000;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = ~VAL_MIN;

    // Every block input has a known value from time zero.
    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]         i_cfg_wr_data = '0;
    logic                     i_in_valid    = 1'b0;
    logic [SRC_W-1:0]         i_source      = '0;
    logic signed [DATA_W-1:0] i_value       = '0;
    logic                     i_exhausted   = 1'b0;
    logic                     i_out_ready   = 1'b0;

    logic                     o_in_ready;
    logic                     o_out_valid;
    logic signed [DATA_W-1:0] o_out_value;
    logic [SRC_W-1:0]         o_out_source;
    logic                     o_done_res;
    logic                     o_error;

    int fail_count;
    int pending_results;

    // Knobs shared between the stimulus and the receiver process.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_len      = 0;
    int req_count     = 0;
    int cur_sources   = MAX_SOURCES;   // clamped source count, for building sequences
    int cycle_count   = 0;

    // Sorted source streams for the merge being driven.
    int stream_val [MAX_SOURCES][MAX_RUN_LEN];
    int stream_len [MAX_SOURCES];
    int stream_pos [MAX_SOURCES];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    k_way_merge_engine_core #(
        .MAX_SOURCES(MAX_SOURCES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_source      (i_source),
        .i_value       (i_value),
        .i_exhausted   (i_exhausted),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_value   (o_out_value),
        .o_out_source  (o_out_source),
        .o_done_res    (o_done_res),
        .o_error       (o_error)
    );

    kwm_merge_monitor #(
        .MAX_SOURCES(MAX_SOURCES)
    ) merge_mon (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_source      (i_source),
        .i_value       (i_value),
        .i_exhausted   (i_exhausted),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out_value   (o_out_value),
        .i_out_source  (o_out_source),
        .i_done_res    (o_done_res),
        .i_error       (o_error),
        .o_fail_count  (fail_count),
        .o_pending     (pending_results)
    );

    // Receiver: random stalls at stall_pct; a requested hold-off (set through hold_len
    // and counted here) keeps ready low while the sender keeps offering requests.
    always begin
        @(posedge i_clk);
        if (hold_len != 0) begin
            i_out_ready <= 1'b0;
            repeat (hold_len) @(posedge i_clk);
            hold_len = 0;
        end
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one request, with random idle cycles in front, and return at the
    // edge where it is taken. Valid stays high so the next request can follow
    // back to back; whoever idles next drops it.
    task automatic send_req(input logic [SRC_W-1:0] s, input logic signed [DATA_W-1:0] v,
                            input logic ex);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_source    <= s;
        i_value     <= v;
        i_exhausted <= ex;
        do @(posedge i_clk); while (!o_in_ready);
        req_count++;
    endtask

    // Stop offering, wait for every expected result and for the block to settle.
    // The first edge lets the monitor count a request taken at this very edge.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write, only from idle; it also restarts the merge.
    task automatic set_source_count(input logic [CFG_W-1:0] cnt);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= cnt;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cur_sources = (cnt == 0) ? 1 : ((int'(cnt) > MAX_SOURCES) ? MAX_SOURCES : int'(cnt));
    endtask

    // One merge: fill in random source order, then refill whichever source holds
    // the smallest head until all are exhausted. Stray requests (beyond the count,
    // repeated fill answers, wrong source while draining) are mixed in. Some
    // merges are cut short; the caller must then restart with a register write.
    task automatic merge_run(output bit cut_short);
        int n;
        int i;
        int j;
        int k;
        int want;
        int fidx;
        int steps;
        int abandon_at;
        int s;
        int perm [MAX_SOURCES];
        int head [MAX_SOURCES];
        bit live [MAX_SOURCES];
        bit answered [MAX_SOURCES];
        bit fill;
        longint nxt;

        n = cur_sources;
        cut_short = 1'b0;
        abandon_at = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 25) : -1;

        for (i = 0; i < MAX_SOURCES; i++) begin
            live[i] = 1'b0;
            answered[i] = 1'b0;
            perm[i] = i;
        end

        // Ascending streams: full-range, clustered near zero (ties), or at the extremes.
        for (i = 0; i < n; i++) begin
            stream_len[i] = $urandom_range(0, MAX_RUN_LEN);
            stream_pos[i] = 0;
            case ($urandom_range(0, 9))
                0:       nxt = VAL_MIN;
                1:       nxt = longint'(VAL_MAX) - longint'($urandom_range(0, 3));
                2, 3, 4: nxt = int'($urandom_range(0, 6)) - 3;
                default: nxt = int'($urandom());
            endcase
            for (j = 0; j < stream_len[i]; j++) begin
                stream_val[i][j] = int'(nxt);
                nxt += ($urandom_range(0, 2) == 0) ? longint'($urandom_range(0, 1 << 24))
                                                   : longint'($urandom_range(0, 2));
                if (nxt > VAL_MAX) nxt = VAL_MAX;
            end
        end

        for (i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            k = perm[i];
            perm[i] = perm[j];
            perm[j] = k;
        end

        fill = 1'b1;
        fidx = 0;
        steps = 0;
        forever begin
            if (fill) begin
                want = perm[fidx];
            end else begin
                // Source the block waits on: smallest live head, lowest index on ties.
                want = -1;
                for (i = 0; i < n; i++)
                    if (live[i] && (want < 0 || head[i] < head[want])) want = i;
                if (want < 0) break;    // done result goes out, block is back in fill
            end

            if ($urandom_range(0, 99) < NOISE_PCT) begin
                s = $urandom_range(0, MAX_SOURCES - 1);
                if (s >= n || (fill && answered[s]) || (!fill && s != want))
                    send_req(SRC_W'(s), $urandom(), 1'($urandom_range(0, 1)));
            end

            if (steps == abandon_at) begin
                cut_short = 1'b1;
                return;
            end

            if (stream_pos[want] < stream_len[want]) begin
                head[want] = stream_val[want][stream_pos[want]];
                live[want] = 1'b1;
                send_req(SRC_W'(want), head[want], 1'b0);
            end else begin
                live[want] = 1'b0;
                send_req(SRC_W'(want), $urandom(), 1'b1);   // value is don't-care
            end
            stream_pos[want]++;

            if (fill) begin
                answered[want] = 1'b1;
                fidx++;
                if (fidx == n) fill = 1'b0;
            end
            steps++;
        end
    endtask

    initial begin : stimulus
        int ph;
        int base;
        bit cut_short;
        logic [CFG_W-1:0] phase_cfg;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, eight sources out of reset: extremes, a tie between sources 0
        // and 3, exhausted marks in fill, a repeated fill answer and a wrong
        // source while draining.
        send_req(3'd0, VAL_MIN, 1'b0);
        send_req(3'd1, VAL_MAX, 1'b0);
        send_req(3'd2, $urandom(), 1'b1);
        send_req(3'd0, VAL_MAX, 1'b0);      // already answered: error
        send_req(3'd3, VAL_MIN, 1'b0);
        send_req(3'd4, 0, 1'b0);
        send_req(3'd5, $urandom(), 1'b1);
        send_req(3'd6, -1, 1'b0);
        send_req(3'd7, 5, 1'b0);            // fill complete: source 0 wins the tie
        send_req(3'd3, 7, 1'b0);            // block waits on source 0: error
        send_req(3'd0, $urandom(), 1'b1);
        send_req(3'd3, $urandom(), 1'b1);
        send_req(3'd6, $urandom(), 1'b1);
        send_req(3'd4, $urandom(), 1'b1);
        send_req(3'd7, $urandom(), 1'b1);
        send_req(3'd1, $urandom(), 1'b1);   // nothing live: done

        // Two sources, with a request beyond the count.
        set_source_count(4'd2);
        send_req(3'd5, 9, 1'b0);
        send_req(3'd0, 3, 1'b0);
        send_req(3'd1, $urandom(), 1'b1);
        send_req(3'd0, $urandom(), 1'b1);

        // Zero acts as one source.
        set_source_count(4'd0);
        send_req(3'd1, 1, 1'b0);
        send_req(3'd0, $urandom(), 1'b1);

        // Above the maximum acts as the maximum.
        set_source_count(4'd15);

        // Random merges in four idling phases.
        base = req_count;
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  phase_cfg = 4'd8;  end
                1: begin send_idle_pct = 82; stall_pct = 0;  phase_cfg = 4'd5;  end
                2: begin send_idle_pct = 0;  stall_pct = 82; phase_cfg = 4'd1;  end
                default: begin send_idle_pct = 28; stall_pct = 28; phase_cfg = 4'd15; end
            endcase
            set_source_count(phase_cfg);
            // Back up the output while a full eight-source fill streams in.
            if (ph == 0) hold_len = HOLD_CYCLES;
            while (req_count < base + (ph + 1) * ITEMS_PER_PHASE) begin
                merge_run(cut_short);
                if (cut_short || $urandom_range(0, 3) == 0)
                    set_source_count(CFG_W'($urandom_range(0, 15)));
            end
        end

        wait_idle();
        if (fail_count == 0 && pending_results == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
